>>> rtl/core/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types, action codes and register offsets of the parallel
// interface/timer register block.
// ----------------------------------------------------------------------------
package pit_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  localparam int CntW = 24;
  localparam int PendW = 32;

  localparam logic [5:0] REG_GCR  = 6'h01;
  localparam logic [5:0] REG_SRR  = 6'h03;
  localparam logic [5:0] REG_DDRA = 6'h05;
  localparam logic [5:0] REG_DDRB = 6'h07;
  localparam logic [5:0] REG_DDRC = 6'h09;
  localparam logic [5:0] REG_PVR  = 6'h0B;
  localparam logic [5:0] REG_PACR = 6'h0D;
  localparam logic [5:0] REG_PBCR = 6'h0F;
  localparam logic [5:0] REG_PADR = 6'h11;
  localparam logic [5:0] REG_PBDR = 6'h13;
  localparam logic [5:0] REG_PAAR = 6'h15;
  localparam logic [5:0] REG_PBAR = 6'h17;
  localparam logic [5:0] REG_PCDR = 6'h19;
  localparam logic [5:0] REG_PSR  = 6'h1B;
  localparam logic [5:0] REG_TCR  = 6'h21;
  localparam logic [5:0] REG_TVR  = 6'h23;
  localparam logic [5:0] REG_CPRH = 6'h27;
  localparam logic [5:0] REG_CPRM = 6'h29;
  localparam logic [5:0] REG_CPRL = 6'h2B;
  localparam logic [5:0] REG_CNTH = 6'h2F;
  localparam logic [5:0] REG_CNTM = 6'h31;
  localparam logic [5:0] REG_CNTL = 6'h33;
  localparam logic [5:0] REG_TSR  = 6'h35;

  localparam logic [7:0] UNMAPPED_RD = 8'hFF;
  localparam logic [7:0] PVR_MASK    = 8'hFC;
  localparam logic [7:0] VEC_MASK    = 8'hFE;
  localparam logic [2:0] MODE_A      = 3'd5;
  localparam logic [2:0] MODE_B      = 3'd7;
  localparam logic [CntW-1:0] CNT_ROLL = 24'hFF_FFFF;

  typedef struct packed {
    action_t         action;
    logic [5:0]      reg_offset;
    logic [7:0]      write_data;
    logic [CntW-1:0] elapsed_ticks;
    logic [3:0]      handshake_edges;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [2:0] irq_level;
    logic [7:0] irq_vector;
  } result_t;

  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CntW-1:0]  count;
    logic [7:0]       status;
    logic             counting;
    logic             req;
  } timer_next_t;

endpackage

>>> rtl/core/parallel_interface_timer_regs_top.sv
// ----------------------------------------------------------------------------
// parallel_interface_timer_regs_top
// Parallel interface/timer register model: bus reads and writes, timer
// ticks and vectored handshake interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per access: a
//   register read, a register write or a time tick. Each word yields one
//   result word on the output channel (out_valid/out_ready): read byte, or
//   the interrupt request, level and vector raised by a tick.
//   A word is captured in the input register, evaluated by single-pass
//   register logic and lands in the result register, which raises out_valid;
//   throughput one word per cycle while the receiver does not stall.
//   The result register holds while the receiver stalls; the input register
//   still takes a word, then in_ready drops until the result drains.
//   cfg_write with cfg_data sets the interrupt level; write it while idle.
//   Synchronous reset returns all registers to their power-up values (level
//   3, vectors 0x0F, port C data and port status 0xAA) and empties both
//   stages.
// ----------------------------------------------------------------------------
module parallel_interface_timer_regs_top import pit_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [2:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      action,
  input  logic [5:0]      reg_offset,
  input  logic [7:0]      write_data,
  input  logic [CntW-1:0] elapsed_ticks,
  input  logic [3:0]      handshake_edges,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      read_data,
  output logic            irq_request,
  output logic [2:0]      irq_level,
  output logic [7:0]      irq_vector
);

  logic       irq_level_cfg;
  logic [2:0] level;
  logic       stage_valid;
  item_t      stage;
  logic       advance;
  result_t    res;
  result_t    out_reg;

  assign irq_level_cfg = cfg_write;
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 3'd3;
    end else if (irq_level_cfg) begin
      level <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.action          <= action_t'(action);
      stage.reg_offset      <= reg_offset;
      stage.write_data      <= write_data;
      stage.elapsed_ticks   <= elapsed_ticks;
      stage.handshake_edges <= handshake_edges;
    end
  end

  pit_bank u_bank (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (stage),
    .level (level),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign read_data   = out_reg.read_data;
  assign irq_request = out_reg.irq_request;
  assign irq_level   = out_reg.irq_level;
  assign irq_vector  = out_reg.irq_vector;

endmodule

>>> rtl/core/pit_timer.sv
// ----------------------------------------------------------------------------
// pit_timer
// Tick update of the 24-bit counter: saturating accumulation of elapsed
// time, count down, expiry with reload or rollover.
// ----------------------------------------------------------------------------
module pit_timer import pit_pkg::*; (
  input  logic [7:0]       timer_control,
  input  logic [7:0]       timer_status,
  input  logic [CntW-1:0]  preload_value,
  input  logic [CntW-1:0]  count_value,
  input  logic [PendW-1:0] pending_ticks,
  input  logic [CntW-1:0]  elapsed_ticks,
  output timer_next_t      nxt
);

  logic [PendW:0]   sum;
  logic [PendW-1:0] pend_sat;
  logic [2:0]       mode;
  logic             expire;

  assign sum      = {1'b0, pending_ticks} + {{(PendW+1-CntW){1'b0}}, elapsed_ticks};
  assign pend_sat = sum[PendW] ? {PendW{1'b1}} : sum[PendW-1:0];
  assign mode     = timer_control[7:5];
  assign expire   = pend_sat >= {{(PendW-CntW){1'b0}}, count_value};

  always_comb begin
    nxt.counting = (mode == MODE_A) || (mode == MODE_B);
    nxt.pending  = pend_sat;
    nxt.count    = count_value;
    nxt.status   = timer_status;
    if (nxt.counting) begin
      nxt.pending = '0;
      if (expire) begin
        nxt.status = timer_status | 8'h01;
        nxt.count  = timer_control[4] ? CNT_ROLL : preload_value;
      end else begin
        nxt.count = count_value - pend_sat[CntW-1:0];
      end
    end
    nxt.req = nxt.counting && nxt.status[0];
  end

endmodule

>>> rtl/core/pit_bank.sv
// ----------------------------------------------------------------------------
// pit_bank
// Register bank: byte reads and writes, timer tick and handshake line
// service with vectored requests.
// ----------------------------------------------------------------------------
module pit_bank import pit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [2:0] level,
  output result_t    res
);

  logic [7:0]       general_control;
  logic [7:0]       service_request;
  logic [7:0]       direction_abc [3];
  logic [7:0]       port_vector;
  logic             vector_written;
  logic [7:0]       port_control_ab [2];
  logic [7:0]       port_data_abc [3];
  logic [7:0]       port_status;
  logic [7:0]       timer_control;
  logic [7:0]       timer_vector;
  logic [7:0]       timer_status;
  logic [CntW-1:0]  preload_value;
  logic [CntW-1:0]  count_value;
  logic [3:0]       handshake_latch;
  logic [PendW-1:0] pending_ticks;

  timer_next_t      tn;
  logic             tmr_on;
  logic [3:0]       latch_in;
  logic [3:0]       srv;
  logic [3:0]       latch_next;
  logic [7:0]       flags;
  logic [7:0]       rd;
  logic             req;
  logic [7:0]       vec;

  function automatic logic [7:0] line_vec(input logic [7:0] pv, input logic wr,
                                          input logic [1:0] b);
    line_vec = wr ? ((pv & VEC_MASK) + {6'b0, b}) : pv;
  endfunction

  pit_timer u_timer (
    .timer_control (timer_control),
    .timer_status  (timer_status),
    .preload_value (preload_value),
    .count_value   (count_value),
    .pending_ticks (pending_ticks),
    .elapsed_ticks (item.elapsed_ticks),
    .nxt           (tn)
  );

  assign tmr_on   = timer_control[0];
  assign latch_in = handshake_latch | item.handshake_edges;

  always_comb begin
    srv = '0;
    if (general_control[7:6] == 2'b00) begin
      srv[3] = general_control[5] && !port_control_ab[1][5] && port_control_ab[1][2]
               && latch_in[3];
      srv[2] = general_control[5] && port_control_ab[1][1] && latch_in[2];
      srv[1] = general_control[4] && !port_control_ab[0][5] && port_control_ab[0][2]
               && latch_in[1];
      srv[0] = general_control[4] && port_control_ab[0][1] && latch_in[0];
    end
    latch_next = latch_in & ~srv;
    flags = ({8{srv[3]}} & 8'h88) | ({8{srv[2]}} & 8'h44)
          | ({8{srv[1]}} & 8'h22) | ({8{srv[0]}} & 8'h11);
  end

  always_comb begin
    req = 1'b0;
    vec = 8'h00;
    if (item.action == ACT_TICK) begin
      req = (tmr_on && tn.req) || (srv != 4'b0000);
      priority if (srv[0]) vec = line_vec(port_vector, vector_written, 2'd0);
      else if (srv[1])     vec = line_vec(port_vector, vector_written, 2'd1);
      else if (srv[2])     vec = line_vec(port_vector, vector_written, 2'd2);
      else if (srv[3])     vec = line_vec(port_vector, vector_written, 2'd3);
      else if (tmr_on && tn.req) vec = timer_vector;
      else vec = 8'h00;
    end
  end

  always_comb begin
    unique case (item.reg_offset)
      REG_GCR:  rd = general_control;
      REG_SRR:  rd = service_request;
      REG_DDRA: rd = direction_abc[0];
      REG_DDRB: rd = direction_abc[1];
      REG_DDRC: rd = direction_abc[2];
      REG_PVR:  rd = port_vector;
      REG_PACR: rd = port_control_ab[0];
      REG_PBCR: rd = port_control_ab[1];
      REG_PADR: rd = port_data_abc[0];
      REG_PBDR: rd = port_data_abc[1];
      REG_PAAR: rd = 8'h00;
      REG_PBAR: rd = 8'h00;
      REG_PCDR: rd = port_data_abc[2];
      REG_PSR:  rd = port_status;
      REG_TCR:  rd = timer_control;
      REG_TVR:  rd = timer_vector;
      REG_CPRH: rd = preload_value[23:16];
      REG_CPRM: rd = preload_value[15:8];
      REG_CPRL: rd = preload_value[7:0];
      REG_CNTH: rd = count_value[23:16];
      REG_CNTM: rd = count_value[15:8];
      REG_CNTL: rd = count_value[7:0];
      REG_TSR:  rd = timer_status;
      default:  rd = UNMAPPED_RD;
    endcase
  end

  always_comb begin
    res.read_data   = (item.action == ACT_READ) ? rd : 8'h00;
    res.irq_request = req;
    res.irq_level   = req ? level : 3'd0;
    res.irq_vector  = vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      general_control    <= '0;
      service_request    <= '0;
      direction_abc[0]   <= '0;
      direction_abc[1]   <= '0;
      direction_abc[2]   <= '0;
      port_vector        <= 8'h0F;
      vector_written     <= 1'b0;
      port_control_ab[0] <= '0;
      port_control_ab[1] <= '0;
      port_data_abc[0]   <= '0;
      port_data_abc[1]   <= '0;
      port_data_abc[2]   <= 8'hAA;
      port_status        <= 8'hAA;
      timer_control      <= '0;
      timer_vector       <= 8'h0F;
      timer_status       <= '0;
      preload_value      <= '0;
      count_value        <= '0;
      handshake_latch    <= '0;
      pending_ticks      <= '0;
    end else if (fire) begin
      unique case (item.action)
        ACT_WRITE: begin
          unique case (item.reg_offset)
            REG_GCR:  general_control    <= item.write_data;
            REG_SRR:  service_request    <= item.write_data;
            REG_DDRA: direction_abc[0]   <= item.write_data;
            REG_DDRB: direction_abc[1]   <= item.write_data;
            REG_DDRC: direction_abc[2]   <= item.write_data;
            REG_PVR: begin
              port_vector    <= item.write_data & PVR_MASK;
              vector_written <= 1'b1;
            end
            REG_PACR: port_control_ab[0] <= item.write_data;
            REG_PBCR: port_control_ab[1] <= item.write_data;
            REG_PADR: port_data_abc[0]   <= item.write_data;
            REG_PBDR: port_data_abc[1]   <= item.write_data;
            REG_PCDR: port_data_abc[2]   <= item.write_data;
            REG_PSR:  port_status <= port_status & ~{4'h0, item.write_data[3:0]};
            REG_TCR:  timer_control      <= item.write_data;
            REG_TVR:  timer_vector       <= item.write_data;
            REG_CPRH: begin
              preload_value[23:16] <= item.write_data;
              count_value[23:16]   <= item.write_data;
            end
            REG_CPRM: begin
              preload_value[15:8] <= item.write_data;
              count_value[15:8]   <= item.write_data;
            end
            REG_CPRL: begin
              preload_value[7:0] <= item.write_data;
              count_value[7:0]   <= item.write_data;
            end
            REG_CNTH: count_value[23:16] <= item.write_data;
            REG_CNTM: count_value[15:8]  <= item.write_data;
            REG_CNTL: count_value[7:0]   <= item.write_data;
            REG_TSR: begin
              if (item.write_data[0]) timer_status <= 8'h00;
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          handshake_latch <= latch_next;
          port_status     <= port_status | flags;
          if (tmr_on) begin
            pending_ticks <= tn.pending;
            count_value   <= tn.count;
            timer_status  <= tn.status;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
